// ===== rtl/dpl_pkg.sv =====
// Shared types and constants for the demand paging unit.
// No dependencies; imported by demand_paging_lru_unit_top.
package dpl_pkg;

  localparam int MaxFrames    = 64;
  localparam int MaxProcesses = 16;
  localparam int MaxPages     = 64;

  localparam int FrameW = $clog2(MaxFrames);
  localparam int PidW   = $clog2(MaxProcesses);
  localparam int PageW  = $clog2(MaxPages);
  localparam int IdxW   = PidW + PageW;
  localparam int CntW   = PageW + 1;

  localparam logic [1:0] CFG_IPP = 2'd0;
  localparam logic [1:0] CFG_FS  = 2'd1;
  localparam logic [1:0] CFG_MPP = 2'd2;
  localparam logic [1:0] CFG_FIU = 2'd3;

  typedef enum logic [1:0] {
    MODE_ADMIT   = 2'd0,
    MODE_ACCESS  = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVER     = 2'd2,
    ST_NO_FRAME = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV,
    S_PAGES,
    S_MUL,
    S_ADMIT_CHK,
    S_REL_PF,
    S_REL_OWN,
    S_REL_UNL,
    S_ADMIT_EVAL,
    S_PLACE,
    S_ACC_VAL,
    S_ACC_PF,
    S_ACC_OWN,
    S_ACC_CHK,
    S_HIT_PUSH,
    S_VIC_FREE,
    S_MISS_SRCH,
    S_DONE
  } state_e;

endpackage

// ===== rtl/demand_paging_lru_unit_top.sv =====
// Demand paging unit with LRU replacement: sequencer, divider and frame memories.
// Depends on dpl_pkg.
//
// One item at a time; the next item is accepted the cycle after a result is
// loaded. An access runs the bit-serial address divider, then page-table and
// frame-table reads, then the victim free and frame search when it evicts. An
// admit runs the divider, sizes and checks the process, releases its earlier
// admit page by page, then places each page of the new process; a release
// reads the page table and then the frame table for each page. The result
// register frees the input side while a result waits to be taken.
module demand_paging_lru_unit_top
  import dpl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  process_id_i,
  input  logic [15:0] instruction_count_i,
  input  logic [15:0] virtual_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        page_fault_o,
  output logic [5:0]  frame_o,
  output logic        evicted_o,
  output logic [3:0]  evicted_process_o,
  output logic [5:0]  evicted_page_o,
  output logic [6:0]  pages_resident_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [22:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [16:0] ipp_q, fs_q;
  logic [22:0] mpp_q;
  logic [6:0]  fiu_q;

  logic [1:0]        mode_q, mode_d;
  logic [PidW-1:0]   pid_q, pid_d;
  logic [16:0]       rem_q, rem_d;
  logic [15:0]       quo_q, quo_d;
  logic [3:0]        dcnt_q, dcnt_d;
  logic [16:0]       pages_q, pages_d;
  logic [23:0]       prod_q, prod_d;
  logic [CntW-1:0]   pg_q, pg_d;
  logic [FrameW-1:0] f_q, f_d;

  logic [MaxFrames-1:0] busy_q, busy_d;
  logic [CntW-1:0]      cnt_q [MaxProcesses];
  logic                 cnt_we;
  logic [CntW-1:0]      cnt_wdata;
  logic [FrameW-1:0]    head_q, head_d, tail_q, tail_d;
  logic                 empty_q, empty_d;

  // result staging and output register
  logic [1:0]        rs_status_q, rs_status_d;
  logic              rs_fault_q, rs_fault_d;
  logic [5:0]        rs_frame_q, rs_frame_d;
  logic              rs_ev_q, rs_ev_d;
  logic [3:0]        rs_evp_q, rs_evp_d;
  logic [5:0]        rs_evpg_q, rs_evpg_d;
  logic [6:0]        rs_placed_q, rs_placed_d;
  logic              out_valid_q, out_valid_d, out_load;

  // memories
  logic [FrameW-1:0]    pf_mem [MaxProcesses*MaxPages];
  logic [IdxW-1:0]      own_mem [MaxFrames];
  logic [FrameW-1:0]    nx_mem [MaxFrames];
  logic [FrameW-1:0]    pv_mem [MaxFrames];
  logic [FrameW-1:0]    pf_rdata_q;
  logic [IdxW-1:0]      own_rdata_q;
  logic [FrameW-1:0]    nx_rdata_q, pv_rdata_q;
  logic [IdxW-1:0]      pf_addr;
  logic [FrameW-1:0]    fr_raddr;
  logic                 pf_we, own_we, nx_we, pv_we;
  logic [FrameW-1:0]    pf_wdata, nx_waddr, nx_wdata, pv_waddr, pv_wdata, own_waddr;

  logic [16:0]       dvs;
  logic [17:0]       trial;
  logic              lf_found;
  logic [FrameW-1:0] lf_idx;
  logic              unlink_en, place_en, push_en, resident;
  logic [FrameW-1:0] unlink_f, place_f, push_f;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign dvs   = (ipp_q == 17'd0) ? 17'd1 : ipp_q;
  assign trial = {rem_q, quo_q[15]};
  assign pf_addr = {pid_q, pg_q[PageW-1:0]};
  assign resident = busy_q[f_q] && (own_rdata_q == {pid_q, pg_q[PageW-1:0]});

  // lowest free frame below the frame limit
  always_comb begin
    lf_found = 1'b0;
    lf_idx   = '0;
    for (int i = MaxFrames - 1; i >= 0; i--) begin
      if (!busy_q[i] && (7'(i) < fiu_q)) begin
        lf_found = 1'b1;
        lf_idx   = FrameW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d = mode_q; pid_d = pid_q; rem_d = rem_q; quo_d = quo_q; dcnt_d = dcnt_q;
    pages_d = pages_q; prod_d = prod_q; pg_d = pg_q; f_d = f_q;
    busy_d = busy_q; head_d = head_q; tail_d = tail_q; empty_d = empty_q;
    cnt_we = 1'b0; cnt_wdata = '0;
    rs_status_d = rs_status_q; rs_fault_d = rs_fault_q; rs_frame_d = rs_frame_q;
    rs_ev_d = rs_ev_q; rs_evp_d = rs_evp_q; rs_evpg_d = rs_evpg_q;
    rs_placed_d = rs_placed_q;
    fr_raddr = f_q;
    pf_we = 1'b0; pf_wdata = '0;
    own_we = 1'b0; own_waddr = '0;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
    unlink_en = 1'b0; unlink_f = '0;
    place_en = 1'b0; place_f = '0;
    push_en = 1'b0; push_f = '0;
    out_load = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d = mode_i;
          pid_d  = process_id_i;
          rs_status_d = ST_INVALID; rs_fault_d = 1'b0; rs_frame_d = '0;
          rs_ev_d = 1'b0; rs_evp_d = '0; rs_evpg_d = '0; rs_placed_d = '0;
          rem_d = '0; dcnt_d = '0; pg_d = '0;
          quo_d = (mode_i == MODE_ADMIT) ? instruction_count_i : virtual_address_i;
          case (mode_i)
            MODE_ADMIT, MODE_ACCESS: state_d = S_DIV;
            MODE_RELEASE: begin
              if (cnt_q[process_id_i] != '0) state_d = S_REL_PF;
              else state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, dvs}) begin
          rem_d = 17'(trial - {1'b0, dvs});
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = trial[16:0];
          quo_d = {quo_q[14:0], 1'b0};
        end
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'd15) state_d = (mode_q == MODE_ADMIT) ? S_PAGES : S_ACC_VAL;
      end
      S_PAGES: begin
        pages_d = 17'(quo_q) + 17'(rem_q != '0) + 17'd1;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = 24'(pages_q[CntW-1:0]) * 24'(fs_q);
        state_d = S_ADMIT_CHK;
      end
      S_ADMIT_CHK: begin
        pg_d = '0;
        if (cnt_q[pid_q] != '0) state_d = S_REL_PF;
        else state_d = S_ADMIT_EVAL;
      end
      // release loop: page table read, frame table read, free
      S_REL_PF: begin
        if (pg_q >= cnt_q[pid_q]) begin
          cnt_we = 1'b1;
          pg_d   = '0;
          if (mode_q == MODE_ADMIT) begin
            state_d = S_ADMIT_EVAL;
          end else begin
            rs_status_d = ST_OK;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_REL_OWN;
        end
      end
      S_REL_OWN: begin
        fr_raddr = pf_rdata_q;
        f_d = pf_rdata_q;
        state_d = S_REL_UNL;
      end
      S_REL_UNL: begin
        if (resident) begin
          busy_d[f_q] = 1'b0;
          unlink_en = 1'b1;
          unlink_f  = f_q;
        end
        pg_d = pg_q + CntW'(1);
        state_d = S_REL_PF;
      end
      S_ADMIT_EVAL: begin
        if (pages_q > 17'(MaxPages) || prod_q > {1'b0, mpp_q}) begin
          rs_status_d = ST_OVER;
          state_d = S_DONE;
        end else begin
          cnt_we = 1'b1;
          cnt_wdata = pages_q[CntW-1:0];
          pg_d = '0;
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        if (17'(pg_q) == pages_q) begin
          rs_status_d = ST_OK;
          state_d = S_DONE;
        end else begin
          if (lf_found) begin
            place_en = 1'b1;
            place_f  = lf_idx;
            rs_placed_d = rs_placed_q + 7'd1;
          end
          pg_d = pg_q + CntW'(1);
        end
      end
      S_ACC_VAL: begin
        if (quo_q < 16'(cnt_q[pid_q])) begin
          pg_d = {1'b0, quo_q[PageW-1:0]};
          state_d = S_ACC_PF;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ACC_PF: state_d = S_ACC_OWN;
      S_ACC_OWN: begin
        fr_raddr = pf_rdata_q;
        f_d = pf_rdata_q;
        state_d = S_ACC_CHK;
      end
      S_ACC_CHK: begin
        fr_raddr = tail_q;
        if (resident) begin
          unlink_en = 1'b1;
          unlink_f  = f_q;
          rs_frame_d = 6'(f_q);
          rs_status_d = ST_OK;
          state_d = S_HIT_PUSH;
        end else begin
          rs_fault_d = 1'b1;
          if (lf_found) begin
            place_en = 1'b1;
            place_f  = lf_idx;
            rs_frame_d = 6'(lf_idx);
            rs_status_d = ST_OK;
            state_d = S_DONE;
          end else if (!empty_q) begin
            // fetch the least recent frame for eviction
            f_d = tail_q;
            state_d = S_VIC_FREE;
          end else begin
            rs_status_d = ST_NO_FRAME;
            state_d = S_DONE;
          end
        end
      end
      S_HIT_PUSH: begin
        push_en = 1'b1;
        push_f  = f_q;
        state_d = S_DONE;
      end
      S_VIC_FREE: begin
        rs_ev_d   = 1'b1;
        rs_evp_d  = 4'(own_rdata_q[IdxW-1:PageW]);
        rs_evpg_d = 6'(own_rdata_q[PageW-1:0]);
        busy_d[f_q] = 1'b0;
        unlink_en = 1'b1;
        unlink_f  = f_q;
        state_d = S_MISS_SRCH;
      end
      S_MISS_SRCH: begin
        if (lf_found) begin
          place_en = 1'b1;
          place_f  = lf_idx;
          rs_frame_d = 6'(lf_idx);
          rs_status_d = ST_OK;
        end else begin
          rs_status_d = ST_NO_FRAME;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // unlink from the recency list; neighbors come from the frame-table read
    if (unlink_en && !empty_q) begin
      if (head_q == unlink_f && tail_q == unlink_f) begin
        empty_d = 1'b1;
      end else if (head_q == unlink_f) begin
        head_d = nx_rdata_q;
      end else if (tail_q == unlink_f) begin
        tail_d = pv_rdata_q;
      end else begin
        nx_we = 1'b1; nx_waddr = pv_rdata_q; nx_wdata = nx_rdata_q;
        pv_we = 1'b1; pv_waddr = nx_rdata_q; pv_wdata = pv_rdata_q;
      end
    end

    if (place_en) begin
      busy_d[place_f] = 1'b1;
      own_we = 1'b1; own_waddr = place_f;
      pf_we = 1'b1; pf_wdata = place_f;
      push_en = 1'b1;
      push_f  = place_f;
    end

    // push to the most recent end
    if (push_en) begin
      if (empty_q) begin
        head_d = push_f; tail_d = push_f; empty_d = 1'b0;
      end else begin
        nx_we = 1'b1; nx_waddr = push_f; nx_wdata = head_q;
        pv_we = 1'b1; pv_waddr = head_q; pv_wdata = push_f;
        head_d = push_f;
      end
    end

    out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ipp_q <= 17'd32; fs_q <= 17'd64; mpp_q <= 23'd4096; fiu_q <= 7'd64;
      busy_q <= '0;
      head_q <= '0; tail_q <= '0; empty_q <= 1'b1;
      for (int i = 0; i < MaxProcesses; i++) cnt_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q <= busy_d;
      head_q <= head_d; tail_q <= tail_d; empty_q <= empty_d;
      if (cnt_we) cnt_q[pid_q] <= cnt_wdata;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_IPP: ipp_q <= cfg_data_i[16:0];
          CFG_FS:  fs_q  <= cfg_data_i[16:0];
          CFG_MPP: mpp_q <= cfg_data_i;
          CFG_FIU: fiu_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; pid_q <= pid_d; rem_q <= rem_d; quo_q <= quo_d;
    dcnt_q <= dcnt_d; pages_q <= pages_d; prod_q <= prod_d; pg_q <= pg_d; f_q <= f_d;
    rs_status_q <= rs_status_d; rs_fault_q <= rs_fault_d; rs_frame_q <= rs_frame_d;
    rs_ev_q <= rs_ev_d; rs_evp_q <= rs_evp_d; rs_evpg_q <= rs_evpg_d;
    rs_placed_q <= rs_placed_d;
    if (out_load) begin
      status_o <= rs_status_q; page_fault_o <= rs_fault_q; frame_o <= rs_frame_q;
      evicted_o <= rs_ev_q; evicted_process_o <= rs_evp_q;
      evicted_page_o <= rs_evpg_q; pages_resident_o <= rs_placed_q;
    end
  end

  // page table and frame tables
  always_ff @(posedge clk_i) begin
    if (pf_we) pf_mem[pf_addr] <= pf_wdata;
    pf_rdata_q <= pf_mem[pf_addr];
  end

  always_ff @(posedge clk_i) begin
    if (own_we) own_mem[own_waddr] <= pf_addr;
    own_rdata_q <= own_mem[fr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
    nx_rdata_q <= nx_mem[fr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
    pv_rdata_q <= pv_mem[fr_raddr];
  end

  assign out_valid_o = out_valid_q;

  a_evict_needs_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> page_fault_o)
    else $error("eviction without page fault");

  a_fail_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (frame_o == '0))
    else $error("frame reported on failed item");

  a_fault_no_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && page_fault_o |-> (pages_resident_o == '0))
    else $error("access reported admitted pages");

endmodule

// ===== sim/tb_demand_paging_lru_unit_top.sv =====
// Self-checking testbench for demand_paging_lru_unit_top: directed table, then random
// admit/access/release and unknown-mode traffic checked against an in-bench LRU paging predictor.
// Depends on dpl_pkg and the demand_paging_lru_unit_top RTL.
`timescale 1ns / 100ps

module tb_demand_paging_lru_unit_top;
  import dpl_pkg::*;

  localparam logic [1:0] ModeUnknown = 2'd3;
  localparam int WatchLimit = 6000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    status_e    status;
    logic       fault;
    logic [5:0] frame;
    logic       ev;
    logic [3:0] ev_pid;
    logic [5:0] ev_page;
    logic [6:0] placed;
  } page_res_t;

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  pid;
    logic [15:0] icount;
    logic [15:0] vaddr;
    bit          typed;
    page_res_t   res;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [3:0]  process_id_i = '0;
  logic [15:0] instruction_count_i = '0;
  logic [15:0] virtual_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        page_fault_o;
  logic [5:0]  frame_o;
  logic        evicted_o;
  logic [3:0]  evicted_process_o;
  logic [5:0]  evicted_page_o;
  logic [6:0]  pages_resident_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [22:0] cfg_data_i = '0;

  demand_paging_lru_unit_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // paging state mirror
  int unsigned ipp_reg, fsize_reg, mem_limit_reg, frame_limit_reg;
  bit          busy_map [MaxFrames];
  int unsigned owner_pid [MaxFrames];
  int unsigned owner_page [MaxFrames];
  int unsigned lru_next [MaxFrames];
  int unsigned lru_prev [MaxFrames];
  int unsigned lru_head, lru_tail;
  bit          lru_empty;
  bit          resident [MaxProcesses*MaxPages];
  int unsigned page_loc [MaxProcesses*MaxPages];
  int unsigned proc_pages [MaxProcesses];

  page_res_t expected_q [$];
  int        mismatches = 0;
  bit        no_idle = 1'b0;
  int        hold_req = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  bit        timed_out = 1'b0;

  function automatic void lru_unlink(int unsigned f);
    if (lru_empty) return;
    if (lru_head == f && lru_tail == f) lru_empty = 1'b1;
    else if (lru_head == f) lru_head = lru_next[f];
    else if (lru_tail == f) lru_tail = lru_prev[f];
    else begin
      lru_next[lru_prev[f]] = lru_next[f];
      lru_prev[lru_next[f]] = lru_prev[f];
    end
  endfunction

  function automatic void lru_touch(int unsigned f);
    if (lru_empty) begin
      lru_head = f;
      lru_tail = f;
      lru_empty = 1'b0;
    end else begin
      lru_next[f] = lru_head;
      lru_prev[lru_head] = f;
      lru_head = f;
    end
  endfunction

  function automatic int first_free_frame();
    int unsigned lim;
    lim = frame_limit_reg < MaxFrames ? frame_limit_reg : MaxFrames;
    for (int i = 0; i < lim; i++) if (!busy_map[i]) return i;
    return -1;
  endfunction

  function automatic void map_page(int unsigned pid, int unsigned pg, int unsigned f);
    busy_map[f] = 1'b1;
    owner_pid[f] = pid;
    owner_page[f] = pg;
    resident[pid*MaxPages + pg] = 1'b1;
    page_loc[pid*MaxPages + pg] = f;
    lru_touch(f);
  endfunction

  function automatic void unmap_frame(int unsigned f);
    resident[owner_pid[f]*MaxPages + owner_page[f]] = 1'b0;
    busy_map[f] = 1'b0;
    lru_unlink(f);
  endfunction

  function automatic void drop_process(int unsigned pid);
    for (int unsigned p = 0; p < proc_pages[pid]; p++)
      if (resident[pid*MaxPages + p]) unmap_frame(page_loc[pid*MaxPages + p]);
    proc_pages[pid] = 0;
  endfunction

  function automatic void paging_reset();
    ipp_reg = 32;
    fsize_reg = 64;
    mem_limit_reg = 4096;
    frame_limit_reg = 64;
    foreach (busy_map[i]) busy_map[i] = 1'b0;
    foreach (resident[i]) resident[i] = 1'b0;
    foreach (proc_pages[i]) proc_pages[i] = 0;
    lru_empty = 1'b1;
    lru_head = 0;
    lru_tail = 0;
  endfunction

  function automatic page_res_t paging_step(logic [1:0] mode, logic [3:0] pid,
                                            logic [15:0] icount, logic [15:0] vaddr);
    page_res_t   r;
    int unsigned ipp, pg, idx, victim;
    longint      pages;
    int          f;
    r = '0;
    r.status = ST_INVALID;
    ipp = ipp_reg == 0 ? 1 : ipp_reg;
    if (mode == MODE_ADMIT) begin
      pages = (longint'(icount) + ipp - 1) / ipp + 1;
      if (proc_pages[pid] != 0) drop_process(pid);
      if (pages > MaxPages || pages * fsize_reg > mem_limit_reg) r.status = ST_OVER;
      else begin
        proc_pages[pid] = 32'(pages);
        for (int unsigned p = 0; p < pages; p++) begin
          f = first_free_frame();
          if (f >= 0) begin
            map_page(pid, p, f);
            r.placed = r.placed + 7'd1;
          end
        end
        r.status = ST_OK;
      end
    end else if (mode == MODE_ACCESS) begin
      pg = vaddr / ipp;
      if (proc_pages[pid] != 0 && pg < proc_pages[pid]) begin
        idx = pid*MaxPages + pg;
        if (resident[idx]) begin
          lru_unlink(page_loc[idx]);
          lru_touch(page_loc[idx]);
          r.frame = 6'(page_loc[idx]);
          r.status = ST_OK;
        end else begin
          f = first_free_frame();
          r.fault = 1'b1;
          if (f < 0 && !lru_empty) begin
            victim = lru_tail;
            r.ev = 1'b1;
            r.ev_pid = 4'(owner_pid[victim]);
            r.ev_page = 6'(owner_page[victim]);
            unmap_frame(victim);
            f = first_free_frame();
          end
          if (f < 0) r.status = ST_NO_FRAME;
          else begin
            map_page(pid, pg, f);
            r.frame = 6'(f);
            r.status = ST_OK;
          end
        end
      end
    end else if (mode == MODE_RELEASE) begin
      if (proc_pages[pid] != 0) begin
        drop_process(pid);
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  // result side: random stalls plus one long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(0, 99) >= 36);
    end
  end

  always @(posedge clk_i) begin
    page_res_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_e'(status_o), page_fault_o, frame_o, evicted_o,
              evicted_process_o, evicted_page_o, pages_resident_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    int quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("tb_demand_paging_lru_unit_top: errors");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] mode, logic [3:0] pid, logic [15:0] icount,
                           logic [15:0] vaddr, bit typed = 1'b0, page_res_t res = '0);
    page_res_t pred;
    if (!no_idle && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    process_id_i <= pid;
    instruction_count_i <= icount;
    virtual_address_i <= vaddr;
    do @(posedge clk_i); while (!in_ready_o);
    pred = paging_step(mode, pid, icount, vaddr);
    expected_q.push_back(typed ? res : pred);
  endtask

  // drop valid and wait for every pending result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] index, int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= 23'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_IPP: ipp_reg = value & 32'h1FFFF;
      CFG_FS:  fsize_reg = value & 32'h1FFFF;
      CFG_MPP: mem_limit_reg = value & 32'h7FFFFF;
      default: frame_limit_reg = value & 32'h7F;
    endcase
  endtask

  task automatic set_phase(int unsigned ipp, int unsigned fs, int unsigned mpp,
                           int unsigned fiu);
    drain();
    write_reg(CFG_IPP, ipp);
    write_reg(CFG_FS, fs);
    write_reg(CFG_MPP, mpp);
    write_reg(CFG_FIU, fiu);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_items(int count);
    logic [1:0]  mode;
    logic [3:0]  pid;
    logic [15:0] ic, va;
    int unsigned ipp, pg, sel;
    longint      addr;
    for (int n = 0; n < count; n++) begin
      ipp = ipp_reg == 0 ? 1 : ipp_reg;
      sel = $urandom_range(0, 99);
      pid = 4'($urandom_range(0, 15));
      ic = 16'($urandom);
      va = 16'($urandom);
      if (sel < 25) begin
        mode = MODE_ADMIT;
        if ($urandom_range(0, 7) != 0) begin
          addr = longint'(ipp) * $urandom_range(0, 14) - $urandom_range(0, ipp - 1);
          ic = addr < 0 ? 16'd0 : (addr > 65535 ? 16'hFFFF : addr[15:0]);
        end
      end else if (sel < 85) begin
        mode = MODE_ACCESS;
        if ($urandom_range(0, 99) < 85) begin
          // prefer admitted processes and in-range pages
          for (int t = 0; t < 4 && proc_pages[pid] == 0; t++)
            pid = 4'($urandom_range(0, 15));
          pg = $urandom_range(0, proc_pages[pid]);
          addr = longint'(pg) * ipp + $urandom_range(0, ipp - 1);
          va = addr > 65535 ? 16'hFFFF : addr[15:0];
        end
      end else if (sel < 95) begin
        mode = MODE_RELEASE;
      end else begin
        mode = ModeUnknown;
      end
      send_item(mode, pid, ic, va);
    end
  endtask

  table_row_t dir_rows [$];

  initial begin
    paging_reset();
    dir_rows = '{
      '{MODE_ACCESS, 4'd0, 16'd0, 16'd0, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0, 0}},
      '{MODE_RELEASE, 4'd3, 16'd0, 16'd0, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0, 0}},
      '{ModeUnknown, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0, 0}},
      '{MODE_ADMIT, 4'd0, 16'hFFFF, 16'd0, 1'b1, '{ST_OVER, 0, 0, 0, 0, 0, 0}},
      '{MODE_ADMIT, 4'd1, 16'd0, 16'd0, 1'b1, '{ST_OK, 0, 0, 0, 0, 0, 7'd1}},
      '{MODE_ADMIT, 4'd2, 16'd2016, 16'd0, 1'b1, '{ST_OK, 0, 0, 0, 0, 0, 7'd63}},
      '{MODE_ACCESS, 4'd2, 16'd0, 16'd2047, 1'b1, '{ST_OK, 1, 0, 1, 4'd1, 6'd0, 0}},
      '{MODE_ACCESS, 4'd15, 16'd0, 16'd0, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0, 0}},
      '{MODE_ACCESS, 4'd2, 16'd0, 16'hFFFF, 1'b1, '{ST_INVALID, 0, 0, 0, 0, 0, 0}},
      '{MODE_ADMIT, 4'd15, 16'd2017, 16'd0, 1'b1, '{ST_OVER, 0, 0, 0, 0, 0, 0}},
      '{MODE_ACCESS, 4'd1, 16'd0, 16'd31, 1'b0, '0},
      '{MODE_ACCESS, 4'd2, 16'd0, 16'd0, 1'b0, '0},
      '{MODE_ACCESS, 4'd2, 16'd0, 16'd100, 1'b0, '0},
      '{MODE_ADMIT, 4'd2, 16'd100, 16'd0, 1'b0, '0},
      '{MODE_ADMIT, 4'd2, 16'd100, 16'd0, 1'b0, '0},
      '{MODE_ACCESS, 4'd2, 16'd0, 16'd127, 1'b0, '0},
      '{MODE_RELEASE, 4'd1, 16'd0, 16'd0, 1'b0, '0},
      '{MODE_RELEASE, 4'd1, 16'd0, 16'd0, 1'b0, '0},
      '{MODE_ADMIT, 4'd15, 16'd2016, 16'd0, 1'b0, '0},
      '{MODE_ACCESS, 4'd15, 16'd0, 16'd2016, 1'b0, '0},
      '{ModeUnknown, 4'd15, 16'd0, 16'd0, 1'b0, '0},
      '{MODE_RELEASE, 4'd2, 16'd0, 16'd0, 1'b0, '0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].mode, dir_rows[i].pid, dir_rows[i].icount,
                dir_rows[i].vaddr, dir_rows[i].typed, dir_rows[i].res);

    // few frames, tiny pages: heavy eviction; block fills while results are held
    set_phase(1, 1, 4194304, 8);
    random_items(60);
    hold_req++;
    random_items(110);
    drain();
    random_items(30);

    // zero divisor, frame size of 65536
    set_phase(0, 65536, 4194304, 64);
    random_items(150);

    // pages of 65536, single frame
    set_phase(65536, 1, 2, 1);
    random_items(100);

    // frame count above the array, run without idling
    set_phase(7, 100, 3000, 127);
    no_idle = 1'b1;
    random_items(150);
    no_idle = 1'b0;

    // shrink frames under resident pages, then zero memory limit
    set_phase(32, 64, 4096, 20);
    random_items(200);
    set_phase(32, 65536, 0, 64);
    random_items(30);

    drain();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_demand_paging_lru_unit_top: clean");
    end else begin
      $display("tb_demand_paging_lru_unit_top: errors");
    end
    $finish;
  end

endmodule
